// ===== src/preemptive_priority_task_scheduler_defines.svh =====
// Assertion macros shared by the scheduler modules.
`ifndef PREEMPTIVE_PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_TASK_SCHEDULER_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define PPTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("Scheduler assertion failed.");

// Checks that a condition implies a consequence in the same cycle.
`define PPTS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("Scheduler assertion failed.");

`endif

// ===== src/ppts_pkg.sv =====
// Types, constants and codes shared by the scheduler modules.
package ppts_pkg;

  localparam int READY_DEPTH   = 16;
  localparam int PAUSED_DEPTH  = 16;
  localparam int ID_BITS       = 16;
  localparam int PRIORITY_BITS = 8;

  localparam int MODE_W = 3;
  localparam int FPRI_W = 8;
  localparam int FID_W  = 16;
  localparam int ACT_W  = 3;

  localparam int RIDX_W = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
  localparam int PIDX_W = (PAUSED_DEPTH > 1) ? $clog2(PAUSED_DEPTH) : 1;
  localparam int RCNT_W = $clog2(READY_DEPTH + 1);
  localparam int PCNT_W = $clog2(PAUSED_DEPTH + 1);
  localparam int J_W    = (RCNT_W > PCNT_W) ? RCNT_W : PCNT_W;
  localparam int SUM_W  = J_W + 1;
  localparam int SCAN_N = (READY_DEPTH > PAUSED_DEPTH) ? READY_DEPTH : PAUSED_DEPTH;
  localparam int SCAN_W = $clog2(SCAN_N + 1);

  localparam int RES_DEPTH = READY_DEPTH + 2;
  localparam int RES_IDX_W = $clog2(RES_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 3'd0,
    MODE_FINISH = 3'd1,
    MODE_PAUSE  = 3'd2,
    MODE_RESUME = 3'd3,
    MODE_CANCEL = 3'd4
  } mode_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_DONE   = 3'd0,
    ACT_RESUME = 3'd1,
    ACT_PAUSE  = 3'd2,
    ACT_STOP   = 3'd3,
    ACT_IDLE   = 3'd4,
    ACT_REJECT = 3'd5
  } action_e;

  typedef struct packed {
    logic [ID_BITS-1:0]              id;
    logic signed [PRIORITY_BITS-1:0] pri;
    logic                            pmark;
    logic                            cmark;
  } entry_t;

  typedef struct packed {
    logic               we;
    action_e            action;
    logic [ID_BITS-1:0] target;
  } res_t;

  typedef struct packed {
    logic               valid;
    logic               reject;
    logic [ID_BITS-1:0] reject_id;
    logic [ID_BITS-1:0] new_id;
    logic               active_valid;
    logic [ID_BITS-1:0] active_id;
  } fin_t;

endpackage

// ===== src/ppts_core.sv =====
// Command sequencer with the ready and paused task memories.
`include "preemptive_priority_task_scheduler_defines.svh"
module ppts_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_stall_o,
  input  logic [2:0]           mode_i,
  input  logic [7:0]           priority_req_i,
  input  logic [15:0]          task_id_i,
  input  logic                 outq_busy_i,
  output ppts_pkg::res_t       res_o,
  output ppts_pkg::fin_t       fin_o
);

  localparam int RD     = ppts_pkg::READY_DEPTH;
  localparam int PD     = ppts_pkg::PAUSED_DEPTH;
  localparam int IDB    = ppts_pkg::ID_BITS;
  localparam int PRB    = ppts_pkg::PRIORITY_BITS;
  localparam int RIDX_W = ppts_pkg::RIDX_W;
  localparam int PIDX_W = ppts_pkg::PIDX_W;
  localparam int RCNT_W = ppts_pkg::RCNT_W;
  localparam int PCNT_W = ppts_pkg::PCNT_W;
  localparam int J_W    = ppts_pkg::J_W;
  localparam int SUM_W  = ppts_pkg::SUM_W;
  localparam int SCAN_N = ppts_pkg::SCAN_N;
  localparam int SCAN_W = ppts_pkg::SCAN_W;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_SCAN   = 13'b0000000000010,
    S_DECIDE = 13'b0000000000100,
    S_SCHED  = 13'b0000000001000,
    S_START  = 13'b0000000010000,
    S_INS_RD = 13'b0000000100000,
    S_INS_WT = 13'b0000001000000,
    S_RM_RD  = 13'b0000010000000,
    S_RM_WT  = 13'b0000100000000,
    S_POP_RD = 13'b0001000000000,
    S_POP_WT = 13'b0010000000000,
    S_FIN    = 13'b0100000000000,
    S_WAIT   = 13'b1000000000000
  } state_e;

  ppts_pkg::entry_t ready_mem [RD];
  ppts_pkg::entry_t paused_mem [PD];

  state_e state_q, state_d;
  logic [RCNT_W-1:0] rc_q, rc_d;
  logic [PCNT_W-1:0] pc_q, pc_d;
  ppts_pkg::entry_t act_q, act_d;
  logic act_vld_q, act_vld_d;
  logic [IDB-1:0] nid_q, nid_d;
  logic [ppts_pkg::MODE_W-1:0] mode_q, mode_d;
  logic signed [PRB-1:0] pri_q, pri_d;
  logic [IDB-1:0] id_q, id_d;
  ppts_pkg::entry_t t_q, t_d;
  logic [J_W-1:0] j_q, j_d;
  logic rm_sel_q, rm_sel_d;
  logic rm_sched_q, rm_sched_d;
  logic [IDB-1:0] newid_q, newid_d;
  logic reject_q, reject_d;
  logic [IDB-1:0] rej_id_q, rej_id_d;
  logic [SCAN_W-1:0] scan_addr_q, scan_addr_d;
  logic [SCAN_W-1:0] scan_idx_q, scan_idx_d;
  logic scan_vld_q, scan_vld_d;
  logic ri_found_q, ri_found_d;
  logic [RIDX_W-1:0] ri_q, ri_d;
  ppts_pkg::entry_t cap_r_q, cap_r_d;
  logic pi_found_q, pi_found_d;
  logic [PIDX_W-1:0] pi_q, pi_d;
  ppts_pkg::entry_t cap_p_q, cap_p_d;
  logic [RCNT_W-1:0] mt_q, mt_d;

  logic r_re, r_we, p_re, p_we;
  logic [RIDX_W-1:0] r_raddr, r_waddr;
  logic [PIDX_W-1:0] p_raddr, p_waddr;
  ppts_pkg::entry_t r_wdata, p_wdata, r_rdata_q, p_rdata_q, rm_rdata, tmp_e;
  logic is_act, ready_full, cancel;
  logic [J_W-1:0] rm_n;

  always_ff @(posedge clk_i) begin
    if (r_we) begin
      ready_mem[r_waddr] <= r_wdata;
    end
    if (r_re) begin
      r_rdata_q <= ready_mem[r_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      paused_mem[p_waddr] <= p_wdata;
    end
    if (p_re) begin
      p_rdata_q <= paused_mem[p_raddr];
    end
  end

  assign cmd_stall_o = (state_q != S_IDLE);
  assign is_act      = act_vld_q && (act_q.id == id_q);
  assign ready_full  = act_vld_q && (rc_q == RCNT_W'(RD));
  assign cancel      = (mode_q == ppts_pkg::MODE_CANCEL);
  assign rm_n        = rm_sel_q ? J_W'(pc_q) : J_W'(rc_q);
  assign rm_rdata    = rm_sel_q ? p_rdata_q : r_rdata_q;

  always_comb begin
    state_d = state_q;  rc_d = rc_q;  pc_d = pc_q;  act_d = act_q;
    act_vld_d = act_vld_q;  nid_d = nid_q;  mode_d = mode_q;  pri_d = pri_q;
    id_d = id_q;  t_d = t_q;  j_d = j_q;  rm_sel_d = rm_sel_q;
    rm_sched_d = rm_sched_q;  newid_d = newid_q;  reject_d = reject_q;
    rej_id_d = rej_id_q;  scan_addr_d = scan_addr_q;  scan_idx_d = scan_idx_q;
    scan_vld_d = scan_vld_q;  ri_found_d = ri_found_q;  ri_d = ri_q;
    cap_r_d = cap_r_q;  pi_found_d = pi_found_q;  pi_d = pi_q;
    cap_p_d = cap_p_q;  mt_d = mt_q;
    r_re = 1'b0;  r_raddr = '0;  r_we = 1'b0;  r_waddr = '0;  r_wdata = t_q;
    p_re = 1'b0;  p_raddr = '0;  p_we = 1'b0;  p_waddr = '0;  p_wdata = t_q;
    tmp_e = t_q;
    res_o = '0;
    fin_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          mode_d      = mode_i;
          pri_d       = PRB'($signed(priority_req_i));
          id_d        = IDB'(task_id_i);
          newid_d     = '0;
          reject_d    = 1'b0;
          rej_id_d    = '0;
          scan_addr_d = '0;
          scan_vld_d  = 1'b0;
          ri_found_d  = 1'b0;
          pi_found_d  = 1'b0;
          mt_d        = '0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_addr_q < SCAN_W'(SCAN_N)) begin
          if (scan_addr_q < SCAN_W'(RD)) begin
            r_re    = 1'b1;
            r_raddr = RIDX_W'(scan_addr_q);
          end
          if (scan_addr_q < SCAN_W'(PD)) begin
            p_re    = 1'b1;
            p_raddr = PIDX_W'(scan_addr_q);
          end
          scan_addr_d = scan_addr_q + SCAN_W'(1);
          scan_idx_d  = scan_addr_q;
          scan_vld_d  = 1'b1;
        end else begin
          scan_vld_d = 1'b0;
        end
        if (scan_vld_q) begin
          if (scan_idx_q < SCAN_W'(rc_q)) begin
            if (!ri_found_q && (r_rdata_q.id == id_q)) begin
              ri_found_d = 1'b1;
              ri_d       = RIDX_W'(scan_idx_q);
              cap_r_d    = r_rdata_q;
            end
            mt_d = r_rdata_q.pmark ? (mt_q + RCNT_W'(1)) : '0;
          end
          if (scan_idx_q < SCAN_W'(pc_q)) begin
            if (!pi_found_q && (p_rdata_q.id == id_q)) begin
              pi_found_d = 1'b1;
              pi_d       = PIDX_W'(scan_idx_q);
              cap_p_d    = p_rdata_q;
            end
          end
          if (scan_idx_q == SCAN_W'(SCAN_N - 1)) begin
            state_d = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        state_d = S_FIN;
        if (mode_q == ppts_pkg::MODE_PUSH) begin
          if (ready_full) begin
            reject_d = 1'b1;
          end else begin
            t_d     = '{id: nid_q, pri: pri_q, pmark: 1'b0, cmark: 1'b0};
            newid_d = nid_q;
            nid_d   = nid_q + IDB'(1);
            state_d = S_SCHED;
          end
        end else if (mode_q == ppts_pkg::MODE_FINISH) begin
          if (is_act) begin
            if ((SUM_W'(mt_q) + SUM_W'(pc_q)) > SUM_W'(PD)) begin
              reject_d = 1'b1;
              rej_id_d = id_q;
            end else begin
              act_vld_d = 1'b0;
              state_d   = S_POP_RD;
            end
          end else if (ri_found_q) begin
            rm_sel_d   = 1'b0;
            rm_sched_d = 1'b0;
            j_d        = J_W'(ri_q);
            state_d    = S_RM_RD;
          end
        end else if (mode_q == ppts_pkg::MODE_PAUSE) begin
          if (is_act) begin
            if ((SUM_W'(mt_q) + SUM_W'(pc_q) + SUM_W'(1)) > SUM_W'(PD)) begin
              reject_d = 1'b1;
              rej_id_d = id_q;
            end else begin
              res_o       = '{we: 1'b1, action: ppts_pkg::ACT_PAUSE, target: act_q.id};
              tmp_e       = act_q;
              tmp_e.pmark = 1'b0;
              p_we        = 1'b1;
              p_waddr     = PIDX_W'(pc_q);
              p_wdata     = tmp_e;
              pc_d        = pc_q + PCNT_W'(1);
              act_vld_d   = 1'b0;
              state_d     = S_POP_RD;
            end
          end else if (ri_found_q) begin
            tmp_e       = cap_r_q;
            tmp_e.pmark = 1'b1;
            r_we        = 1'b1;
            r_waddr     = ri_q;
            r_wdata     = tmp_e;
          end else if (pi_found_q) begin
            tmp_e       = cap_p_q;
            tmp_e.pmark = 1'b1;
            p_we        = 1'b1;
            p_waddr     = pi_q;
            p_wdata     = tmp_e;
          end
        end else if ((mode_q == ppts_pkg::MODE_RESUME) || cancel) begin
          if (cancel && is_act) begin
            res_o = '{we: 1'b1, action: ppts_pkg::ACT_STOP, target: act_q.id};
          end else if (ri_found_q) begin
            if (cancel) begin
              tmp_e       = cap_r_q;
              tmp_e.cmark = 1'b1;
              r_we        = 1'b1;
              r_waddr     = ri_q;
              r_wdata     = tmp_e;
            end
          end else if (pi_found_q) begin
            if (ready_full) begin
              reject_d = 1'b1;
              rej_id_d = id_q;
            end else begin
              tmp_e       = cap_p_q;
              tmp_e.cmark = cap_p_q.cmark | cancel;
              t_d         = tmp_e;
              rm_sel_d    = 1'b1;
              rm_sched_d  = 1'b1;
              j_d         = J_W'(pi_q);
              state_d     = S_RM_RD;
            end
          end
        end
      end
      S_SCHED: begin
        if (!act_vld_q) begin
          act_d     = t_q;
          act_vld_d = 1'b1;
          state_d   = S_START;
        end else if ($signed(act_q.pri) < $signed(t_q.pri)) begin
          res_o       = '{we: 1'b1, action: ppts_pkg::ACT_PAUSE, target: act_q.id};
          tmp_e       = act_q;
          tmp_e.pmark = 1'b0;
          r_we        = 1'b1;
          r_waddr     = RIDX_W'(rc_q);
          r_wdata     = tmp_e;
          rc_d        = rc_q + RCNT_W'(1);
          act_d       = t_q;
          state_d     = S_START;
        end else begin
          j_d     = J_W'(rc_q);
          state_d = S_INS_RD;
        end
      end
      S_START: begin
        res_o   = '{we: 1'b1,
                    action: act_q.cmark ? ppts_pkg::ACT_STOP : ppts_pkg::ACT_RESUME,
                    target: act_q.id};
        state_d = S_FIN;
      end
      S_INS_RD: begin
        if (j_q == '0) begin
          r_we    = 1'b1;
          r_waddr = '0;
          r_wdata = t_q;
          rc_d    = rc_q + RCNT_W'(1);
          state_d = S_FIN;
        end else begin
          r_re    = 1'b1;
          r_raddr = RIDX_W'(j_q - J_W'(1));
          state_d = S_INS_WT;
        end
      end
      S_INS_WT: begin
        r_we    = 1'b1;
        r_waddr = RIDX_W'(j_q);
        if ($signed(r_rdata_q.pri) >= $signed(t_q.pri)) begin
          r_wdata = r_rdata_q;
          j_d     = j_q - J_W'(1);
          state_d = S_INS_RD;
        end else begin
          r_wdata = t_q;
          rc_d    = rc_q + RCNT_W'(1);
          state_d = S_FIN;
        end
      end
      S_RM_RD: begin
        if ((j_q + J_W'(1)) < rm_n) begin
          r_re    = !rm_sel_q;
          p_re    = rm_sel_q;
          r_raddr = RIDX_W'(j_q + J_W'(1));
          p_raddr = PIDX_W'(j_q + J_W'(1));
          state_d = S_RM_WT;
        end else begin
          if (rm_sel_q) begin
            pc_d = pc_q - PCNT_W'(1);
          end else begin
            rc_d = rc_q - RCNT_W'(1);
          end
          state_d = rm_sched_q ? S_SCHED : S_FIN;
        end
      end
      S_RM_WT: begin
        r_we    = !rm_sel_q;
        p_we    = rm_sel_q;
        r_waddr = RIDX_W'(j_q);
        p_waddr = PIDX_W'(j_q);
        r_wdata = rm_rdata;
        p_wdata = rm_rdata;
        j_d     = j_q + J_W'(1);
        state_d = S_RM_RD;
      end
      S_POP_RD: begin
        if (rc_q != '0) begin
          r_re    = 1'b1;
          r_raddr = RIDX_W'(rc_q - RCNT_W'(1));
          state_d = S_POP_WT;
        end else begin
          if (pc_q == '0) begin
            res_o = '{we: 1'b1, action: ppts_pkg::ACT_IDLE, target: '0};
          end
          state_d = S_FIN;
        end
      end
      S_POP_WT: begin
        rc_d = rc_q - RCNT_W'(1);
        if (r_rdata_q.pmark && (pc_q < PCNT_W'(PD))) begin
          res_o       = '{we: 1'b1, action: ppts_pkg::ACT_PAUSE, target: r_rdata_q.id};
          tmp_e       = r_rdata_q;
          tmp_e.pmark = 1'b0;
          p_we        = 1'b1;
          p_waddr     = PIDX_W'(pc_q);
          p_wdata     = tmp_e;
          pc_d        = pc_q + PCNT_W'(1);
          state_d     = S_POP_RD;
        end else begin
          act_d     = r_rdata_q;
          act_vld_d = 1'b1;
          state_d   = S_START;
        end
      end
      S_FIN: begin
        fin_o.valid        = 1'b1;
        fin_o.reject       = reject_q;
        fin_o.reject_id    = rej_id_q;
        fin_o.new_id       = reject_q ? '0 : newid_q;
        fin_o.active_valid = act_vld_q;
        fin_o.active_id    = act_vld_q ? act_q.id : '0;
        state_d            = S_WAIT;
      end
      S_WAIT: begin
        if (!outq_busy_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rc_q       <= '0;
      pc_q       <= '0;
      act_q      <= '0;
      act_vld_q  <= 1'b0;
      nid_q      <= '0;
      scan_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rc_q       <= rc_d;
      pc_q       <= pc_d;
      act_q      <= act_d;
      act_vld_q  <= act_vld_d;
      nid_q      <= nid_d;
      scan_vld_q <= scan_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    pri_q       <= pri_d;
    id_q        <= id_d;
    t_q         <= t_d;
    j_q         <= j_d;
    rm_sel_q    <= rm_sel_d;
    rm_sched_q  <= rm_sched_d;
    newid_q     <= newid_d;
    reject_q    <= reject_d;
    rej_id_q    <= rej_id_d;
    scan_addr_q <= scan_addr_d;
    scan_idx_q  <= scan_idx_d;
    ri_found_q  <= ri_found_d;
    ri_q        <= ri_d;
    cap_r_q     <= cap_r_d;
    pi_found_q  <= pi_found_d;
    pi_q        <= pi_d;
    cap_p_q     <= cap_p_d;
    mt_q        <= mt_d;
  end

  `PPTS_ASSERT(a_ready_count_bound, rc_q <= RCNT_W'(RD))
  `PPTS_ASSERT(a_paused_count_bound, pc_q <= PCNT_W'(PD))
  `PPTS_ASSERT_IMPL(a_idle_no_write, state_q == S_IDLE, !r_we && !p_we && !res_o.we)

endmodule

// ===== src/ppts_outq.sv =====
// Result buffer and output register that replays a command's results.
`include "preemptive_priority_task_scheduler_defines.svh"
module ppts_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ppts_pkg::res_t res_i,
  input  ppts_pkg::fin_t fin_i,
  output logic           busy_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [2:0]     action_o,
  output logic [15:0]    target_id_o,
  output logic [15:0]    new_id_o,
  output logic           active_valid_o,
  output logic [15:0]    active_id_o,
  output logic           last_o
);

  localparam int RDEP  = ppts_pkg::RES_DEPTH;
  localparam int RIW   = ppts_pkg::RES_IDX_W;
  localparam int FW    = ppts_pkg::FID_W;
  localparam int IDB   = ppts_pkg::ID_BITS;
  localparam int BUFW  = (RDEP > 1) ? $clog2(RDEP) : 1;

  ppts_pkg::res_t buf_mem [RDEP];
  logic [RIW-1:0] cnt_q, cnt_d;
  logic [RIW-1:0] eidx_q, eidx_d;
  logic busy_q, busy_d;
  ppts_pkg::fin_t fin_q, fin_d;
  logic ov_q, ov_d;
  ppts_pkg::action_e oact_q, oact_d;
  logic [IDB-1:0] otgt_q, otgt_d;
  logic olast_q, olast_d;
  logic [IDB-1:0] onew_q, onew_d;
  logic oav_q, oav_d;
  logic [IDB-1:0] oaid_q, oaid_d;
  ppts_pkg::res_t rd_e;

  assign rd_e = buf_mem[BUFW'(eidx_q)];

  always_ff @(posedge clk_i) begin
    if (res_i.we) begin
      buf_mem[BUFW'(cnt_q)] <= res_i;
    end
  end

  always_comb begin
    cnt_d   = cnt_q;
    eidx_d  = eidx_q;
    busy_d  = busy_q;
    fin_d   = fin_q;
    ov_d    = ov_q;
    oact_d  = oact_q;
    otgt_d  = otgt_q;
    olast_d = olast_q;
    onew_d  = onew_q;
    oav_d   = oav_q;
    oaid_d  = oaid_q;
    if (res_i.we) begin
      cnt_d = cnt_q + RIW'(1);
    end
    if (ov_q && !out_valid_o) begin
      ov_d = 1'b0;
    end
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
    if (fin_i.valid) begin
      fin_d  = fin_i;
      busy_d = 1'b1;
      eidx_d = '0;
      if (fin_i.reject) begin
        cnt_d = '0;
      end
    end else if (busy_q && (!ov_q || !out_stall_i)) begin
      ov_d   = 1'b1;
      onew_d = fin_q.new_id;
      oav_d  = fin_q.active_valid;
      oaid_d = fin_q.active_id;
      if (eidx_q < cnt_q) begin
        oact_d  = rd_e.action;
        otgt_d  = rd_e.target;
        olast_d = 1'b0;
        eidx_d  = eidx_q + RIW'(1);
      end else begin
        oact_d  = fin_q.reject ? ppts_pkg::ACT_REJECT : ppts_pkg::ACT_DONE;
        otgt_d  = fin_q.reject ? fin_q.reject_id : '0;
        olast_d = 1'b1;
        busy_d  = 1'b0;
        cnt_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eidx_q  <= eidx_d;
    fin_q   <= fin_d;
    oact_q  <= oact_d;
    otgt_q  <= otgt_d;
    olast_q <= olast_d;
    onew_q  <= onew_d;
    oav_q   <= oav_d;
    oaid_q  <= oaid_d;
  end

  assign busy_o         = busy_q;
  assign out_valid_o    = ov_q;
  assign action_o       = oact_q;
  assign target_id_o    = FW'(otgt_q);
  assign new_id_o       = FW'(onew_q);
  assign active_valid_o = oav_q;
  assign active_id_o    = FW'(oaid_q);
  assign last_o         = olast_q;

  `PPTS_ASSERT_IMPL(a_write_fits, res_i.we, cnt_q < RIW'(RDEP))
  `PPTS_ASSERT_IMPL(a_fin_when_free, fin_i.valid, !busy_q)
  `PPTS_ASSERT_IMPL(a_no_write_replay, busy_q, !res_i.we)

endmodule

// ===== src/preemptive_priority_task_scheduler.sv =====
// Preemptive priority task scheduler: one active task, a priority-sorted ready
// store and a paused store, both held in synchronous-read memories with separate read and write addresses.
// Each command is taken only when in_stall_o is low; it first sweeps both
// memories in parallel, then carries out the command, moving one entry at a
// time through a read and a write state for a sorted insert or a removal and
// popping tasks from the ready store one by one. Its results, each carrying
// the active task as it stands after the command, are then replayed through
// an output register, the last one marked by last_o; the next command may
// enter while that final transaction still waits to be taken.
module preemptive_priority_task_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  priority_req_i,
  input  logic [15:0] task_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [15:0] target_id_o,
  output logic [15:0] new_id_o,
  output logic        active_valid_o,
  output logic [15:0] active_id_o,
  output logic        last_o
);

  ppts_pkg::res_t res;
  ppts_pkg::fin_t fin;
  logic           outq_busy;

  ppts_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (in_valid_i),
    .cmd_stall_o    (in_stall_o),
    .mode_i         (mode_i),
    .priority_req_i (priority_req_i),
    .task_id_i      (task_id_i),
    .outq_busy_i    (outq_busy),
    .res_o          (res),
    .fin_o          (fin)
  );

  ppts_outq u_outq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_i          (res),
    .fin_i          (fin),
    .busy_o         (outq_busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_o       (action_o),
    .target_id_o    (target_id_o),
    .new_id_o       (new_id_o),
    .active_valid_o (active_valid_o),
    .active_id_o    (active_id_o),
    .last_o         (last_o)
  );

endmodule

// ===== tb/tb_preemptive_priority_task_scheduler.sv =====
// Self-checking testbench for the preemptive priority task scheduler.
`timescale 1ns / 100ps

module tb_preemptive_priority_task_scheduler;

  typedef struct {
    logic [2:0]  mode;
    logic [7:0]  pri;
    logic [15:0] tid;
  } cmd_t;

  typedef struct {
    logic [2:0]  action;
    logic [15:0] target;
    logic [15:0] new_id;
    logic        act_v;
    logic [15:0] act_id;
    logic        last;
  } res_t;

  typedef struct {
    logic [15:0]       id;
    logic signed [7:0] pri;
    logic              pmark;
    logic              cmark;
  } task_t;

  localparam int LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  mode_i = '0;
  logic [7:0]  priority_req_i = '0;
  logic [15:0] task_id_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  action_o;
  logic [15:0] target_id_o;
  logic [15:0] new_id_o;
  logic        active_valid_o;
  logic [15:0] active_id_o;
  logic        last_o;

  preemptive_priority_task_scheduler u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  cmd_t  pending_cmds[$];
  res_t  expected_results[$];
  int    errors = 0;
  int    cycles = 0;
  bit    hold_sender = 1'b0;

  // Scheduler shadow state.
  task_t       ready_q[$];
  task_t       paused_q[$];
  task_t       running;
  bit          running_ok = 1'b0;
  logic [15:0] next_tid = '0;
  res_t        acts[$];
  logic [15:0] cur_new;
  logic [15:0] issued[$];

  function automatic void note(logic [2:0] a, logic [15:0] t);
    res_t r;
    r.action = a;
    r.target = t;
    r.new_id = cur_new;
    r.act_v = 1'b0;
    r.act_id = '0;
    r.last = 1'b0;
    acts.push_back(r);
  endfunction

  function automatic void start_running();
    note(running.cmark ? ppts_pkg::ACT_STOP : ppts_pkg::ACT_RESUME, running.id);
  endfunction

  function automatic int marked_top();
    int k = 0;
    while (k < ready_q.size() && ready_q[ready_q.size() - 1 - k].pmark) k++;
    return k;
  endfunction

  function automatic void pick_next();
    task_t e;
    forever begin
      if (ready_q.size() > 0) begin
        e = ready_q[ready_q.size() - 1];
        ready_q.delete(ready_q.size() - 1);
        if (e.pmark && paused_q.size() < ppts_pkg::PAUSED_DEPTH) begin
          note(ppts_pkg::ACT_PAUSE, e.id);
          e.pmark = 1'b0;
          paused_q.push_back(e);
          continue;
        end
        running = e;
        running_ok = 1'b1;
        start_running();
        return;
      end
      if (paused_q.size() == 0) note(ppts_pkg::ACT_IDLE, '0);
      return;
    end
  endfunction

  function automatic void place_task(task_t t);
    int i = 0;
    if (!running_ok) begin
      running = t;
      running_ok = 1'b1;
      start_running();
    end else if (running.pri < t.pri) begin
      note(ppts_pkg::ACT_PAUSE, running.id);
      running.pmark = 1'b0;
      ready_q.push_back(running);
      running = t;
      start_running();
    end else begin
      while (i < ready_q.size() && ready_q[i].pri < t.pri) i++;
      ready_q.insert(i, t);
    end
  endfunction

  function automatic int find_task(ref task_t s[$], input logic [15:0] id);
    foreach (s[i]) if (s[i].id == id) return i;
    return -1;
  endfunction

  function automatic void schedule_command(cmd_t c);
    bit    act_hit;
    int    ri, pi;
    bit    rej = 1'b0;
    logic [15:0] rid = c.tid;
    task_t t;
    acts.delete();
    cur_new = '0;
    act_hit = running_ok && running.id == c.tid;
    ri = find_task(ready_q, c.tid);
    pi = find_task(paused_q, c.tid);
    case (c.mode)
      ppts_pkg::MODE_PUSH: begin
        if (running_ok && ready_q.size() >= ppts_pkg::READY_DEPTH) begin
          rej = 1'b1;
          rid = '0;
        end else begin
          t.id = next_tid;
          t.pri = c.pri;
          t.pmark = 1'b0;
          t.cmark = 1'b0;
          cur_new = next_tid;
          issued.push_back(next_tid);
          next_tid++;
          place_task(t);
        end
      end
      ppts_pkg::MODE_FINISH: begin
        if (act_hit) begin
          if (marked_top() > ppts_pkg::PAUSED_DEPTH - paused_q.size()) rej = 1'b1;
          else begin
            running_ok = 1'b0;
            pick_next();
          end
        end else if (ri >= 0) ready_q.delete(ri);
      end
      ppts_pkg::MODE_PAUSE: begin
        if (act_hit) begin
          if (paused_q.size() >= ppts_pkg::PAUSED_DEPTH ||
              marked_top() > ppts_pkg::PAUSED_DEPTH - paused_q.size() - 1) rej = 1'b1;
          else begin
            note(ppts_pkg::ACT_PAUSE, running.id);
            running.pmark = 1'b0;
            paused_q.push_back(running);
            running_ok = 1'b0;
            pick_next();
          end
        end else if (ri >= 0) ready_q[ri].pmark = 1'b1;
        else if (pi >= 0) paused_q[pi].pmark = 1'b1;
      end
      ppts_pkg::MODE_RESUME, ppts_pkg::MODE_CANCEL: begin
        if (c.mode == ppts_pkg::MODE_CANCEL && act_hit) note(ppts_pkg::ACT_STOP, running.id);
        else if (ri >= 0) begin
          if (c.mode == ppts_pkg::MODE_CANCEL) ready_q[ri].cmark = 1'b1;
        end else if (pi >= 0) begin
          if (running_ok && ready_q.size() >= ppts_pkg::READY_DEPTH) rej = 1'b1;
          else begin
            t = paused_q[pi];
            if (c.mode == ppts_pkg::MODE_CANCEL) t.cmark = 1'b1;
            paused_q.delete(pi);
            place_task(t);
          end
        end
      end
      default: ;
    endcase
    if (rej) begin
      acts.delete();
      cur_new = '0;
      note(ppts_pkg::ACT_REJECT, rid);
    end else note(ppts_pkg::ACT_DONE, '0);
    foreach (acts[k]) begin
      acts[k].act_v = running_ok;
      acts[k].act_id = running_ok ? running.id : '0;
      acts[k].last = (k == acts.size() - 1);
      expected_results.push_back(acts[k]);
    end
  endfunction

  // Driver: bursts of transactions separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  cmd_t cur;
  always @(posedge clk_i) begin
    logic nxt_valid;
    nxt_valid = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        schedule_command(cur);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && !(hold_sender && expected_results.size() > 0)) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          cur = pending_cmds.pop_front();
          mode_i <= cur.mode;
          priority_req_i <= cur.pri;
          task_id_i <= cur.tid;
          nxt_valid = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end else burst_left--;
        end
      end
    end
    in_valid_i <= nxt_valid;
  end

  // Receiver stall pattern and result checking.
  int stall_phase = 0;
  always @(posedge clk_i) begin
    res_t e;
    cycles++;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result action=%0d target=%0d", $time, action_o,
                   target_id_o);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if ({action_o, target_id_o, new_id_o, active_valid_o, active_id_o, last_o} !==
              {e.action, e.target, e.new_id, e.act_v, e.act_id, e.last}) begin
            $display("%0t: expected act=%0d tgt=%0d new=%0d av=%0d aid=%0d last=%0d",
                     $time, e.action, e.target, e.new_id, e.act_v, e.act_id, e.last);
            $display("%0t: actual   act=%0d tgt=%0d new=%0d av=%0d aid=%0d last=%0d",
                     $time, action_o, target_id_o, new_id_o, active_valid_o,
                     active_id_o, last_o);
            errors++;
          end
        end
      end
      stall_phase = (stall_phase + 1) % 64;
      if (stall_phase < 20) out_stall_i <= 1'b0;
      else out_stall_i <= ($urandom_range(0, 3) == 0);
    end
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [15:0] some_id();
    int r = $urandom_range(0, 9);
    if (r == 0 || issued.size() == 0) return 16'($urandom);
    if (r < 4 && issued.size() > 0) return issued[issued.size() - 1 - $urandom_range(0,
        (issued.size() > 4) ? 4 : issued.size() - 1)];
    return issued[$urandom_range(0, issued.size() - 1)];
  endfunction

  function automatic cmd_t mk(logic [2:0] m, logic [7:0] p, logic [15:0] id);
    cmd_t c;
    c.mode = m;
    c.pri = p;
    c.tid = id;
    return c;
  endfunction

  initial begin
    int r;
    logic [2:0] m;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: idle finish, extreme priorities, preemption, marks, odd modes.
    pending_cmds.push_back(mk(ppts_pkg::MODE_FINISH, 8'h00, 16'hffff));
    pending_cmds.push_back(mk(ppts_pkg::MODE_PUSH, 8'h80, 16'h0000));
    pending_cmds.push_back(mk(ppts_pkg::MODE_PUSH, 8'h80, 16'h0000));
    pending_cmds.push_back(mk(ppts_pkg::MODE_PUSH, 8'h7f, 16'h0000));
    pending_cmds.push_back(mk(ppts_pkg::MODE_PAUSE, 8'h00, 16'd1));
    pending_cmds.push_back(mk(ppts_pkg::MODE_CANCEL, 8'h00, 16'd0));
    pending_cmds.push_back(mk(ppts_pkg::MODE_CANCEL, 8'h00, 16'd2));
    pending_cmds.push_back(mk(ppts_pkg::MODE_RESUME, 8'h00, 16'd0));
    pending_cmds.push_back(mk(ppts_pkg::MODE_FINISH, 8'h00, 16'd2));
    pending_cmds.push_back(mk(ppts_pkg::MODE_PAUSE, 8'h00, 16'd0));
    pending_cmds.push_back(mk(ppts_pkg::MODE_RESUME, 8'h00, 16'd0));
    pending_cmds.push_back(mk(ppts_pkg::MODE_CANCEL, 8'h00, 16'd1));
    pending_cmds.push_back(mk(3'd5, 8'hff, 16'hffff));
    pending_cmds.push_back(mk(3'd7, 8'h55, 16'haaaa));
    pending_cmds.push_back(mk(ppts_pkg::MODE_FINISH, 8'h00, 16'd1));
    pending_cmds.push_back(mk(ppts_pkg::MODE_FINISH, 8'h00, 16'd0));
    pending_cmds.push_back(mk(ppts_pkg::MODE_FINISH, 8'h00, 16'd2));
    // Track directed identifiers for later targeting.
    for (int i = 0; i < 3; i++) issued.push_back(16'(i));
    while (pending_cmds.size() > 0 || in_valid_i) @(posedge clk_i);
    hold_sender = 1'b1;
    while (expected_results.size() > 0) @(posedge clk_i);
    hold_sender = 1'b0;
    // Random phase: fill toward full stores, then mixed traffic with a second push-heavy stretch.
    for (int i = 0; i < 230; i++) begin
      r = $urandom_range(0, 99);
      if (i < 40 || (i > 120 && i < 150))
        m = (r < 70) ? ppts_pkg::MODE_PUSH : 3'($urandom_range(1, 4));
      else if (r < 30) m = ppts_pkg::MODE_PUSH;
      else if (r < 48) m = ppts_pkg::MODE_FINISH;
      else if (r < 68) m = ppts_pkg::MODE_PAUSE;
      else if (r < 82) m = ppts_pkg::MODE_RESUME;
      else if (r < 97) m = ppts_pkg::MODE_CANCEL;
      else m = 3'($urandom_range(5, 7));
      pending_cmds.push_back(mk(m, 8'($urandom), some_id()));
      while (pending_cmds.size() > 2) @(posedge clk_i);
      if (i == 100) begin
        while (pending_cmds.size() > 0 || in_valid_i) @(posedge clk_i);
        hold_sender = 1'b1;
        while (expected_results.size() > 0) @(posedge clk_i);
        hold_sender = 1'b0;
      end
    end
    while (pending_cmds.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
